>>> src/dclpf_pkg.sv
package dclpf_pkg;

    localparam int AXIS_COUNT_DEF     = 3;
    localparam int HYSTERESIS_DEF     = 5;
    localparam int TWO_PI_Q12         = 25736;

    localparam logic [2:0] REG_MIN_CUTOFF   = 3'd0;
    localparam logic [2:0] REG_MAX_CUTOFF   = 3'd1;
    localparam logic [2:0] REG_THR_PCT      = 3'd2;
    localparam logic [2:0] REG_THR_GAIN     = 3'd3;
    localparam logic [2:0] REG_ERR_THR      = 3'd4;
    localparam logic [2:0] REG_ERR_GAIN     = 3'd5;
    localparam logic [2:0] REG_SMOOTH       = 3'd6;
    localparam logic [2:0] REG_PERIOD       = 3'd7;

    // 1e6 * 2^26 and 1e6 * 2^42
    localparam logic [46:0] GAIN_C   = 47'd67108864000000;
    localparam logic [62:0] GAIN_NUM = 63'd4398046511104000000;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_MODE  = 13'b0000000000010,
        ST_FMIN  = 13'b0000000000100,
        ST_ERR   = 13'b0000000001000,
        ST_EDIV  = 13'b0000000010000,
        ST_CLAMP = 13'b0000000100000,
        ST_GS    = 13'b0000001000000,
        ST_GSDIV = 13'b0000010000000,
        ST_SMUP  = 13'b0000100000000,
        ST_GF    = 13'b0001000000000,
        ST_GFDIV = 13'b0010000000000,
        ST_FUP   = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } state_t;

endpackage

>>> src/dynamic_cutoff_lowpass_filter.sv
// channel  direction  signals
// cfg      in         cfg_valid cfg_ready cfg_index cfg_data
// in       in         in_valid in_ready axis_index gyro_sample setpoint_rate throttle_command
// out      out        out_valid out_ready filtered_sample cutoff_now_hz dynamic_active
// one word runs from accept to out_valid through three restoring divisions of
// 64 quotient bits each, one bit per cycle through one shared subtract-and-compare unit
// axis out of range or error gain zero: result word the cycle after accept
// rst_n clears the axis state, the registers to their defaults and the sequencer
// in_ready is low from accept until the result word is taken on out
module dynamic_cutoff_lowpass_filter #(
    parameter int AXIS_COUNT = dclpf_pkg::AXIS_COUNT_DEF,
    parameter int HYSTERESIS_DPS = dclpf_pkg::HYSTERESIS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [13:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         axis_index,
    input  logic signed [15:0] gyro_sample,
    input  logic signed [15:0] setpoint_rate,
    input  logic [10:0]        throttle_command,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] filtered_sample,
    output logic [9:0]         cutoff_now_hz,
    output logic               dynamic_active
);
    import dclpf_pkg::*;

    localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    logic [9:0]  min_cut_reg, max_cut_reg, smooth_reg;
    logic [6:0]  thr_pct_reg;
    logic [7:0]  thr_gain_reg, err_gain_reg;
    logic [10:0] err_thr_reg;
    logic [13:0] period_reg;

    logic signed [47:0] filt_reg [AXIS_COUNT];
    logic [23:0]        cut_reg  [AXIS_COUNT];
    logic [AXIS_COUNT-1:0] dyn_reg;

    state_t state_reg, state_next;
    logic [AW-1:0]      ax_reg;
    logic signed [15:0] g_reg, sp_reg;
    logic [10:0]        thc_reg;
    logic [18:0]        w_reg;
    logic [29:0]        fmin_reg;
    logic [29:0]        fnew_reg;
    logic [63:0]        num_reg, quo_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        den_reg;
    logic [6:0]         cnt_reg;
    logic signed [15:0] y_reg;
    logic [9:0]         cn_reg;
    logic               dyn_out_reg, out_valid_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = state_reg == ST_IDLE && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign filtered_sample = y_reg;
    assign cutoff_now_hz   = cn_reg;
    assign dynamic_active  = dyn_out_reg;

    // shared restoring divider step
    logic [64:0] trial;
    logic [63:0] rem_sh;
    always_comb
    begin
        rem_sh = {rem_reg[62:0], num_reg[63]};
        trial  = {1'b0, rem_sh} - {1'b0, den_reg};
    end

    // shared rounding pt1 update helper
    function automatic logic signed [47:0] pt1(input logic signed [47:0] s,
                                               input logic signed [47:0] x,
                                               input logic [16:0] k);
        logic signed [65:0] p;
        logic [65:0] m;
        begin
            p = 66'(x - s) * $signed({1'b0, k});
            m = p[65] ? 66'(-p) : p;
            m = (m + 66'd32768) >> 16;
            pt1 = s + (p[65] ? -48'(m) : 48'(m));
        end
    endfunction

    logic signed [47:0] st_cur, st_new;
    logic [23:0] cs_cur, cs_new;
    logic [16:0] k_v;
    logic signed [19:0] lo_v, hi_v;
    logic [16:0] asp;
    logic [47:0] ast;
    logic signed [16:0] sum_v, dif_v;
    logic [16:0] dmag, smag;
    logic signed [12:0] t10;
    logic signed [13:0] exv;
    logic [24:0] cs_rnd;
    logic signed [47:0] y_rnd;
    logic [47:0] y_m;
    always_comb
    begin
        st_cur = filt_reg[ax_reg];
        cs_cur = cut_reg[ax_reg];
        lo_v = (20'(signed'({1'b0, err_thr_reg})) - 20'(HYSTERESIS_DPS)) * 20'sd16;
        hi_v = (20'(signed'({1'b0, err_thr_reg})) + 20'(HYSTERESIS_DPS)) * 20'sd16;
        asp  = sp_reg[15] ? 17'(-17'(sp_reg)) : 17'(sp_reg);
        ast  = st_cur[47] ? 48'(-st_cur) : 48'(st_cur);
        sum_v = 17'(sp_reg) + 17'(g_reg);
        dif_v = 17'(sp_reg) - 17'(g_reg);
        dmag = dif_v[16] ? 17'(-dif_v) : 17'(dif_v);
        smag = sum_v[16] ? 17'(-sum_v) : 17'(sum_v);
        t10  = 13'(signed'({1'b0, thc_reg})) - 13'sd1000;
        exv  = 14'(t10) - 14'(thr_pct_reg) * 14'sd10;
        k_v  = 17'd65536 - 17'(quo_reg);
        cs_new = 24'(pt1(48'(cs_cur), 48'(fnew_reg), k_v));
        st_new = pt1(st_cur, 48'(g_reg) <<< 16, k_v);
        cs_rnd = (25'(cut_reg[ax_reg]) + 25'd8192) >> 14;
        y_m  = st_cur[47] ? 48'(-st_cur) : 48'(st_cur);
        y_m  = (y_m + 48'd32768) >> 16;
        y_rnd = st_cur[47] ? -48'(y_m) : 48'(y_m);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid && in_ready && 32'(axis_index) < AXIS_COUNT
                    && err_gain_reg != 8'd0)
                    state_next = ST_MODE;
            ST_MODE:  state_next = ST_FMIN;
            ST_FMIN:  state_next = ST_ERR;
            ST_ERR:   state_next = ST_EDIV;
            ST_EDIV:  if (cnt_reg == 7'd63) state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_GS;
            ST_GS:    state_next = ST_GSDIV;
            ST_GSDIV: if (cnt_reg == 7'd63) state_next = ST_SMUP;
            ST_SMUP:  state_next = ST_GF;
            ST_GF:    state_next = ST_GFDIV;
            ST_GFDIV: if (cnt_reg == 7'd63) state_next = ST_FUP;
            ST_FUP:   state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            dyn_reg       <= '0;
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                filt_reg[i] <= '0;
                cut_reg[i]  <= '0;
            end
            min_cut_reg  <= 10'd100;
            max_cut_reg  <= 10'd500;
            thr_pct_reg  <= 7'd35;
            thr_gain_reg <= 8'd10;
            err_thr_reg  <= 11'd20;
            err_gain_reg <= 8'd70;
            smooth_reg   <= 10'd50;
            period_reg   <= 14'd125;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_MIN_CUTOFF: min_cut_reg  <= cfg_data[9:0];
                    REG_MAX_CUTOFF: max_cut_reg  <= cfg_data[9:0];
                    REG_THR_PCT:    thr_pct_reg  <= cfg_data[6:0];
                    REG_THR_GAIN:   thr_gain_reg <= cfg_data[7:0];
                    REG_ERR_THR:    err_thr_reg  <= cfg_data[10:0];
                    REG_ERR_GAIN:   err_gain_reg <= cfg_data[7:0];
                    REG_SMOOTH:     smooth_reg   <= cfg_data[9:0];
                    REG_PERIOD:     period_reg   <= cfg_data[13:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_MODE:
                begin
                    w_reg <= (exv > 0) ? 19'(exv[10:0]) * 19'(thr_gain_reg) : '0;
                    if (dyn_reg[ax_reg])
                    begin
                        if ($signed({3'b0, asp}) <= lo_v && !lo_v[19]
                            && ast <= 48'({28'd0, lo_v}) << 16)
                            dyn_reg[ax_reg] <= 1'b0;
                    end
                    else if ($signed({3'b0, asp}) >= hi_v || ast >= 48'(hi_v) << 16)
                        dyn_reg[ax_reg] <= 1'b1;
                end
                ST_FMIN:
                begin
                    // excess * gain * 2^14 / 10 as w * 1638 + floor(2w / 5)
                    fmin_reg <= (30'(min_cut_reg) << 14) + 30'(w_reg) * 30'd1638
                              + 30'((40'(w_reg) * 40'd1677722) >> 22);
                    num_reg  <= 64'(34'(dmag) * 34'(dmag));
                    den_reg  <= 64'(34'(smag) * 34'(smag));
                end
                ST_ERR:
                begin
                    fnew_reg <= fmin_reg;
                    num_reg  <= {46'(num_reg[33:0]) * (46'(err_gain_reg) * 46'd25), 18'd0};
                    rem_reg  <= '0;
                    cnt_reg  <= '0;
                end
                ST_EDIV, ST_GSDIV, ST_GFDIV:
                begin
                    if (!trial[64]) rem_reg <= trial[63:0];
                    else rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[62:0], !trial[64]};
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg + 7'd1;
                end
                ST_CLAMP:
                begin
                    if (dyn_reg[ax_reg])
                    begin
                        if (smag == 0 || 64'(fmin_reg) + quo_reg > 64'(max_cut_reg) << 14)
                            fnew_reg <= 30'(max_cut_reg) << 14;
                        else fnew_reg <= 30'(64'(fmin_reg) + quo_reg);
                    end
                    else if (fmin_reg > 30'(max_cut_reg) << 14)
                        fnew_reg <= 30'(max_cut_reg) << 14;
                end
                ST_GS:
                begin
                    num_reg <= 64'(GAIN_NUM);
                    den_reg <= 64'(GAIN_C) + (64'(smooth_reg) << 14) * 64'(period_reg)
                               * 64'(TWO_PI_Q12);
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
                ST_SMUP:
                begin
                    cut_reg[ax_reg] <= cs_new;
                end
                ST_GF:
                begin
                    num_reg <= 64'(GAIN_NUM);
                    den_reg <= 64'(GAIN_C) + 64'(cs_cur) * 64'(period_reg) * 64'(TWO_PI_Q12);
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
                ST_FUP:
                begin
                    filt_reg[ax_reg] <= st_new;
                end
                ST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    cn_reg <= 10'(cs_rnd);
                    dyn_out_reg <= dyn_reg[ax_reg];
                    if (y_rnd > 48'sd32767) y_reg <= 16'sh7fff;
                    else if (y_rnd < -48'sd32768) y_reg <= 16'sh8000;
                    else y_reg <= y_rnd[15:0];
                end
                default: ;
            endcase
            if (state_reg == ST_IDLE && in_valid && in_ready)
            begin
                g_reg   <= gyro_sample;
                sp_reg  <= setpoint_rate;
                thc_reg <= throttle_command;
                ax_reg  <= AW'(axis_index);
                if (32'(axis_index) >= AXIS_COUNT)
                begin
                    out_valid_reg <= 1'b1;
                    y_reg <= gyro_sample;
                    cn_reg <= '0;
                    dyn_out_reg <= 1'b0;
                end
                else if (err_gain_reg == 8'd0)
                begin
                    out_valid_reg <= 1'b1;
                    y_reg <= gyro_sample;
                    cn_reg <= 10'((25'(cut_reg[AW'(axis_index)]) + 25'd8192) >> 14);
                    dyn_out_reg <= dyn_reg[AW'(axis_index)];
                end
            end
        end
    end

    a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !in_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLAMP |-> $past(cnt_reg) == 7'd63) else $error("short divide");
endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dclpf_pkg::*;

    localparam int AXES = 3;
    localparam int HYST = 5;
    localparam int MAX_SHOWN = 10;
    localparam int FINAL_WAIT = 400;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [15:0] gyro;
        logic signed [15:0] setpoint;
        logic [10:0]        throttle;
    } sample_word_t;

    typedef struct packed {
        logic signed [15:0] filtered;
        logic [9:0]         cutoff;
        logic               dynamic;
    } filter_word_t;

    typedef struct {
        sample_word_t stim;
        logic         known;
        filter_word_t result;
    } table_row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [13:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [1:0] axis_index;
    logic signed [15:0] gyro_sample;
    logic signed [15:0] setpoint_rate;
    logic [10:0] throttle_command;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] filtered_sample;
    logic [9:0] cutoff_now_hz;
    logic dynamic_active;

    dynamic_cutoff_lowpass_filter i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .axis_index(axis_index),
        .gyro_sample(gyro_sample),
        .setpoint_rate(setpoint_rate),
        .throttle_command(throttle_command),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .filtered_sample(filtered_sample),
        .cutoff_now_hz(cutoff_now_hz),
        .dynamic_active(dynamic_active)
    );

    // predictor state
    longint unsigned reg_val [8];
    longint filt_state [AXES];
    longint cutoff_state [AXES];
    bit mode_state [AXES];

    filter_word_t expected_words [$];
    int mismatch_count;
    int sender_idle_pct;
    int receiver_idle_pct;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    function automatic longint round_off(longint p, int sh);
        longint unsigned m;
        m = p < 0 ? longint'(-p) : longint'(p);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return p < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint lowpass_gain(longint unsigned f_q14, longint unsigned period);
        longint unsigned c;
        longint unsigned n;
        longint unsigned q;
        c = 64'd1000000 << 26;
        n = f_q14 * period * TWO_PI_Q12;
        q = (64'd1000000 << 42) / (c + n);
        return 65536 - longint'(q);
    endfunction

    function automatic longint lowpass_update(longint s, longint x, longint k);
        return s + round_off((x - s) * k, 16);
    endfunction

    function automatic filter_word_t filter_sample(sample_word_t w);
        filter_word_t r;
        longint g;
        longint sp;
        longint t10;
        longint thr;
        longint lo;
        longint hi;
        longint st;
        longint y;
        longint sum;
        longint unsigned d;
        longint unsigned fmin;
        longint unsigned fmax;
        longint unsigned fnew;
        int ax;
        ax = w.axis;
        g = w.gyro;
        sp = w.setpoint;
        t10 = longint'(w.throttle) - 1000;
        thr = reg_val[REG_ERR_THR];
        if (ax >= AXES) begin
            r.filtered = w.gyro;
            r.cutoff = '0;
            r.dynamic = 1'b0;
            return r;
        end
        if (reg_val[REG_ERR_GAIN] == 0) begin
            r.filtered = w.gyro;
            r.cutoff = 10'(round_off(cutoff_state[ax], 14));
            r.dynamic = mode_state[ax];
            return r;
        end
        st = filt_state[ax];
        lo = (thr - HYST) * 16;
        hi = (thr + HYST) * 16;
        if (mode_state[ax]) begin
            if ((sp < 0 ? -sp : sp) <= lo && (st < 0 ? -st : st) <= lo * 65536)
                mode_state[ax] = 1'b0;
        end
        else begin
            if ((sp < 0 ? -sp : sp) >= hi || (st < 0 ? -st : st) >= hi * 65536)
                mode_state[ax] = 1'b1;
        end
        fmin = reg_val[REG_MIN_CUTOFF] << 14;
        if (t10 > longint'(reg_val[REG_THR_PCT]) * 10)
            fmin += ((longint'(t10 - longint'(reg_val[REG_THR_PCT]) * 10)
                      * reg_val[REG_THR_GAIN]) << 14) / 10;
        fmax = reg_val[REG_MAX_CUTOFF] << 14;
        fnew = fmin;
        if (mode_state[ax]) begin
            sum = sp + g;
            d = (sp - g) < 0 ? g - sp : sp - g;
            if (sum == 0)
                fnew = fmax;
            else
                fnew = fmin + (reg_val[REG_ERR_GAIN] * 400 * 16384 * (d * d))
                       / longint'(sum * sum);
        end
        if (fnew > fmax)
            fnew = fmax;
        cutoff_state[ax] = lowpass_update(cutoff_state[ax], longint'(fnew),
            lowpass_gain(reg_val[REG_SMOOTH] << 14, reg_val[REG_PERIOD]));
        st = lowpass_update(st, g * 65536,
            lowpass_gain(cutoff_state[ax], reg_val[REG_PERIOD]));
        filt_state[ax] = st;
        y = round_off(st, 16);
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        r.filtered = 16'(y);
        r.cutoff = 10'(round_off(cutoff_state[ax], 14));
        r.dynamic = mode_state[ax];
        return r;
    endfunction

    task automatic write_register(logic [2:0] idx, logic [13:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_CUTOFF, REG_MAX_CUTOFF, REG_SMOOTH: reg_val[idx] = value & 14'h3FF;
            REG_THR_PCT: reg_val[idx] = value & 14'h7F;
            REG_THR_GAIN, REG_ERR_GAIN: reg_val[idx] = value & 14'hFF;
            REG_ERR_THR: reg_val[idx] = value & 14'h7FF;
            default: reg_val[idx] = value;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
        repeat (FINAL_WAIT) @(posedge clk);
    endtask

    task automatic send_sample(sample_word_t w);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        axis_index <= w.axis;
        gyro_sample <= w.gyro;
        setpoint_rate <= w.setpoint;
        throttle_command <= w.throttle;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_words.push_back(filter_sample(w));
    endtask

    task automatic check_word(filter_word_t exp_w, filter_word_t got_w);
        if (exp_w !== got_w) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
                $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                    exp_w.filtered, exp_w.cutoff, exp_w.dynamic,
                    got_w.filtered, got_w.cutoff, got_w.dynamic);
        end
    endtask

    // receiver
    always @(posedge clk) begin
        filter_word_t got_w;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got_w.filtered = filtered_sample;
                got_w.cutoff = cutoff_now_hz;
                got_w.dynamic = dynamic_active;
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("unexpected word %0d", filtered_sample);
                end
                else
                    check_word(expected_words.pop_front(), got_w);
            end
            out_ready <= !(receiver_idle_pct > 0 && $urandom_range(99) < receiver_idle_pct);
        end
    end

    function automatic sample_word_t random_sample(int small_err);
        sample_word_t w;
        w.axis = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        w.throttle = 11'($urandom_range(2000, 1000));
        if ($urandom_range(9) == 0)
            w.throttle = 11'($urandom);
        w.setpoint = 16'($urandom);
        if (small_err != 0)
            w.gyro = w.setpoint + 16'(int'($urandom_range(400)) - 200);
        else
            w.gyro = 16'($urandom);
        if ($urandom_range(29) == 0)
            w.gyro = -w.setpoint;
        if ($urandom_range(3) == 0) begin
            w.setpoint = 16'(int'($urandom_range(800)) - 400);
            w.gyro = 16'(int'($urandom_range(800)) - 400);
        end
        return w;
    endfunction

    task automatic random_config();
        write_register(REG_MIN_CUTOFF, 14'($urandom_range(1000, 1)));
        write_register(REG_MAX_CUTOFF, 14'($urandom_range(1000, 1)));
        write_register(REG_THR_PCT, 14'($urandom_range(100)));
        write_register(REG_THR_GAIN, 14'($urandom_range(255)));
        write_register(REG_ERR_THR, 14'($urandom_range(60)));
        write_register(REG_ERR_GAIN, 14'($urandom_range(255, 1)));
        write_register(REG_SMOOTH, 14'($urandom_range(1000, 1)));
        write_register(REG_PERIOD, 14'($urandom_range(10000, 31)));
    endtask

    table_row_t directed_rows [$];

    initial begin
        table_row_t row;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        axis_index = '0;
        gyro_sample = '0;
        setpoint_rate = '0;
        throttle_command = 11'd1000;
        out_ready = 1'b0;
        mismatch_count = 0;
        sender_idle_pct = 34;
        receiver_idle_pct = 56;
        reg_val = '{100, 500, 35, 10, 20, 70, 50, 125};
        foreach (filt_state[a])
        begin
            filt_state[a] = 0;
            cutoff_state[a] = 0;
            mode_state[a] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // axis out of range and steady-state rows, then extremes and zero average
        directed_rows = '{
            '{'{2'd3, 16'sh7FFF, 16'sd0, 11'd1000}, 1'b1, '{16'sh7FFF, 10'd0, 1'b0}},
            '{'{2'd3, 16'sh8000, 16'sh7FFF, 11'd2047}, 1'b1, '{16'sh8000, 10'd0, 1'b0}},
            '{'{2'd0, 16'sd0, 16'sd0, 11'd1000}, 1'b0, '0},
            '{'{2'd0, 16'sh7FFF, 16'sh7FFF, 11'd2000}, 1'b0, '0},
            '{'{2'd1, 16'sh8000, 16'sh8000, 11'd1000}, 1'b0, '0},
            '{'{2'd2, 16'sd1000, -16'sd1000, 11'd1500}, 1'b0, '0},
            '{'{2'd2, 16'sd100, 16'sd300, 11'd1700}, 1'b0, '0},
            '{'{2'd0, 16'sh8000, 16'sh7FFF, 11'd0}, 1'b0, '0},
            '{'{2'd1, 16'sd0, 16'sd400, 11'd2047}, 1'b0, '0},
            '{'{2'd1, 16'sd0, 16'sd0, 11'd1000}, 1'b0, '0},
            '{'{2'd0, 16'sd5, 16'sd0, 11'd1350}, 1'b0, '0}
        };
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_sample(row.stim);
            if (row.known)
                check_word(row.result, expected_words[$]);
        end
        wait_drained();

        // min above max, threshold below hysteresis, extremes of every register
        write_register(REG_MIN_CUTOFF, 14'd1000);
        write_register(REG_MAX_CUTOFF, 14'd1);
        write_register(REG_THR_PCT, 14'd0);
        write_register(REG_THR_GAIN, 14'd255);
        write_register(REG_ERR_THR, 14'd2);
        write_register(REG_ERR_GAIN, 14'd255);
        write_register(REG_SMOOTH, 14'd1000);
        write_register(REG_PERIOD, 14'd10000);
        for (int i = 0; i < 8; i++) send_sample(random_sample(i % 2));
        wait_drained();
        write_register(REG_MIN_CUTOFF, 14'd1);
        write_register(REG_MAX_CUTOFF, 14'd1000);
        write_register(REG_THR_PCT, 14'd100);
        write_register(REG_ERR_THR, 14'd2000);
        write_register(REG_SMOOTH, 14'd1);
        write_register(REG_PERIOD, 14'd31);
        for (int i = 0; i < 4; i++) send_sample(random_sample(0));
        wait_drained();
        // bypass
        write_register(REG_ERR_GAIN, 14'd0);
        write_register(REG_ERR_THR, 14'd0);
        for (int i = 0; i < 4; i++) send_sample(random_sample(0));
        wait_drained();
        write_register(REG_THR_GAIN, 14'd0);
        write_register(REG_PERIOD, 14'h3FFF);
        write_register(REG_ERR_GAIN, 14'd1);
        for (int i = 0; i < 4; i++) send_sample(random_sample(1));
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            sender_idle_pct = (p == 0) ? 34 : (p == 1) ? 56 : 0;
            receiver_idle_pct = (p == 0) ? 56 : (p == 1) ? 34 : 0;
            for (int s = 0; s < 4; s++) begin
                random_config();
                for (int i = 0; i < 100; i++) begin
                    send_sample(random_sample($urandom_range(3) != 0));
                    if ($urandom_range(99) == 0) begin
                        in_valid <= 1'b0;
                        @(posedge clk);
                        while (expected_words.size() != 0) @(posedge clk);
                    end
                end
                wait_drained();
            end
        end

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> sim.f
src/dclpf_pkg.sv
src/dynamic_cutoff_lowpass_filter.sv
verif/testbench.sv
